// ----- hdl/hsvrgb_pkg.sv -----
package hsvrgb_pkg;

  // Fraction bits of every level; ONE stands for 1.0.
  localparam int FRAC_BITS = 12;
  localparam int LEVEL_W   = FRAC_BITS + 1;
  localparam int H6_W      = FRAC_BITS + 3;
  localparam int PROD_W    = 2 * LEVEL_W;
  localparam int TDATA_W   = ((3 * LEVEL_W + 7) / 8) * 8;

  localparam logic [LEVEL_W-1:0] ONE = LEVEL_W'(1) << FRAC_BITS;

  typedef logic [LEVEL_W-1:0]   level_t;
  typedef logic [FRAC_BITS-1:0] frac_t;

  // Hue sectors of the six-sector color wheel.
  typedef enum logic [2:0] {
    SECT_RED_YEL  = 3'd0,
    SECT_YEL_GRN  = 3'd1,
    SECT_GRN_CYAN = 3'd2,
    SECT_CYAN_BLU = 3'd3,
    SECT_BLU_MAG  = 3'd4,
    SECT_MAG_RED  = 3'd5
  } sector_t;

  // Word leaving the sector stage.
  typedef struct packed {
    level_t  v;
    level_t  s;
    sector_t sector;
    frac_t   f;
  } sect_t;

  // Word leaving the saturation scaling stage.
  typedef struct packed {
    level_t  v;
    sector_t sector;
    level_t  oms;   // ONE - s
    level_t  qf;    // ONE - s*f
    level_t  tf;    // ONE - s*(ONE-f)
  } scale_t;

  // Word leaving the value scaling stage.
  typedef struct packed {
    level_t  v;
    sector_t sector;
    level_t  p;
    level_t  q;
    level_t  t;
  } shade_t;

  typedef struct packed {
    level_t blue;
    level_t green;
    level_t red;
  } rgb_t;

endpackage

// ----- hdl/hsvrgb_sector.sv -----
module hsvrgb_sector (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  hsvrgb_pkg::level_t    value_i,
  input  hsvrgb_pkg::level_t    hue_i,
  input  hsvrgb_pkg::level_t    sat_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output hsvrgb_pkg::sect_t     data_o
);

  logic                   valid_r;
  hsvrgb_pkg::sect_t      data_r;
  hsvrgb_pkg::sect_t      data_nxt;
  hsvrgb_pkg::frac_t      hue_wrap;
  logic [hsvrgb_pkg::H6_W-1:0] h6;

  // Saturate value and saturation at one, fold a full turn of hue to zero.
  always_comb begin
    hue_wrap = (hue_i >= hsvrgb_pkg::ONE) ? '0 : hue_i[hsvrgb_pkg::FRAC_BITS-1:0];
    h6       = hsvrgb_pkg::H6_W'(hue_wrap) * hsvrgb_pkg::H6_W'(6);
    data_nxt.v      = (value_i > hsvrgb_pkg::ONE) ? hsvrgb_pkg::ONE : value_i;
    data_nxt.s      = (sat_i > hsvrgb_pkg::ONE) ? hsvrgb_pkg::ONE : sat_i;
    data_nxt.sector = hsvrgb_pkg::sector_t'(h6[hsvrgb_pkg::H6_W-1:hsvrgb_pkg::FRAC_BITS]);
    data_nxt.f      = h6[hsvrgb_pkg::FRAC_BITS-1:0];
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

// ----- hdl/hsvrgb_scale.sv -----
module hsvrgb_scale (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  hsvrgb_pkg::sect_t     data_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output hsvrgb_pkg::scale_t    data_o
);

  logic                          valid_r;
  hsvrgb_pkg::scale_t            data_r;
  hsvrgb_pkg::scale_t            data_nxt;
  hsvrgb_pkg::level_t            one_minus_f;
  logic [hsvrgb_pkg::PROD_W-1:0] sf_full;
  logic [hsvrgb_pkg::PROD_W-1:0] st_full;

  // Saturation times the in-sector fraction and its complement, truncated.
  always_comb begin
    one_minus_f = hsvrgb_pkg::ONE - hsvrgb_pkg::LEVEL_W'(data_i.f);
    sf_full = hsvrgb_pkg::PROD_W'(data_i.s) * hsvrgb_pkg::PROD_W'(data_i.f);
    st_full = hsvrgb_pkg::PROD_W'(data_i.s) * hsvrgb_pkg::PROD_W'(one_minus_f);
    data_nxt.v      = data_i.v;
    data_nxt.sector = data_i.sector;
    data_nxt.oms    = hsvrgb_pkg::ONE - data_i.s;
    data_nxt.qf     = hsvrgb_pkg::ONE -
                      sf_full[hsvrgb_pkg::FRAC_BITS +: hsvrgb_pkg::LEVEL_W];
    data_nxt.tf     = hsvrgb_pkg::ONE -
                      st_full[hsvrgb_pkg::FRAC_BITS +: hsvrgb_pkg::LEVEL_W];
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

// ----- hdl/hsvrgb_shade.sv -----
module hsvrgb_shade (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  hsvrgb_pkg::scale_t    data_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output hsvrgb_pkg::shade_t    data_o
);

  logic                          valid_r;
  hsvrgb_pkg::shade_t            data_r;
  hsvrgb_pkg::shade_t            data_nxt;
  logic [hsvrgb_pkg::PROD_W-1:0] p_full;
  logic [hsvrgb_pkg::PROD_W-1:0] q_full;
  logic [hsvrgb_pkg::PROD_W-1:0] t_full;

  // Scale the three factors by value; results never exceed value itself.
  always_comb begin
    p_full = hsvrgb_pkg::PROD_W'(data_i.v) * hsvrgb_pkg::PROD_W'(data_i.oms);
    q_full = hsvrgb_pkg::PROD_W'(data_i.v) * hsvrgb_pkg::PROD_W'(data_i.qf);
    t_full = hsvrgb_pkg::PROD_W'(data_i.v) * hsvrgb_pkg::PROD_W'(data_i.tf);
    data_nxt.v      = data_i.v;
    data_nxt.sector = data_i.sector;
    data_nxt.p      = p_full[hsvrgb_pkg::FRAC_BITS +: hsvrgb_pkg::LEVEL_W];
    data_nxt.q      = q_full[hsvrgb_pkg::FRAC_BITS +: hsvrgb_pkg::LEVEL_W];
    data_nxt.t      = t_full[hsvrgb_pkg::FRAC_BITS +: hsvrgb_pkg::LEVEL_W];
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

// ----- hdl/hsvrgb_route.sv -----
module hsvrgb_route (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  hsvrgb_pkg::shade_t    data_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output hsvrgb_pkg::rgb_t      data_o
);

  logic               valid_r;
  hsvrgb_pkg::rgb_t   data_r;
  hsvrgb_pkg::rgb_t   data_nxt;

  // Six-sector routing of v, p, q and t onto the color channels.
  always_comb begin
    unique case (data_i.sector)
      hsvrgb_pkg::SECT_RED_YEL: begin
        data_nxt.red = data_i.v; data_nxt.green = data_i.t; data_nxt.blue = data_i.p;
      end
      hsvrgb_pkg::SECT_YEL_GRN: begin
        data_nxt.red = data_i.q; data_nxt.green = data_i.v; data_nxt.blue = data_i.p;
      end
      hsvrgb_pkg::SECT_GRN_CYAN: begin
        data_nxt.red = data_i.p; data_nxt.green = data_i.v; data_nxt.blue = data_i.t;
      end
      hsvrgb_pkg::SECT_CYAN_BLU: begin
        data_nxt.red = data_i.p; data_nxt.green = data_i.q; data_nxt.blue = data_i.v;
      end
      hsvrgb_pkg::SECT_BLU_MAG: begin
        data_nxt.red = data_i.t; data_nxt.green = data_i.p; data_nxt.blue = data_i.v;
      end
      default: begin
        data_nxt.red = data_i.v; data_nxt.green = data_i.p; data_nxt.blue = data_i.q;
      end
    endcase
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

// ----- hdl/hsv_to_rgb_converter_unit.sv -----
// HSV to RGB pixel converter using the six-sector color wheel.
// The input channel (in_tvalid, in_tready, in_tdata) carries one pixel per
// word as value, hue and saturation, unsigned fractions with 12 fraction bits
// where 4096 means 1.0. Value and saturation above one are treated as one,
// and a hue of a full turn or more is treated as zero. The output channel
// (out_tvalid, out_tready, out_tdata) carries one word of red, green and blue
// in the same format for each input word, in input order.
// The datapath is a four-stage pipeline: sector and fraction, saturation
// products, value products, and channel routing into the output register.
// Each word passes the sector, scale, shade and route registers in order on its
// way to out_tvalid. Throughput is one pixel per clock while out_tready is
// high; a low out_tready stalls the pipe.
// Each stage has its own valid bit and takes a new word whenever it is empty
// or its word moves on, so bubbles close up while out_tready is low and up to
// four words sit in the pipe. A stall holds every word in place; nothing is
// lost or repeated.
// A synchronous active-low reset empties the pipeline; the block keeps no
// other state.
module hsv_to_rgb_converter_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // Fields from bit 0 up: value_level, hue_angle, saturation_level, zero pad.
  input  logic [hsvrgb_pkg::TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // Fields from bit 0 up: red_level, green_level, blue_level, zero pad.
  output logic [hsvrgb_pkg::TDATA_W-1:0]     out_tdata
);

  hsvrgb_pkg::sect_t  sect_data;
  hsvrgb_pkg::scale_t scale_data;
  hsvrgb_pkg::shade_t shade_data;
  hsvrgb_pkg::rgb_t   rgb_data;
  logic               sect_valid;
  logic               sect_ready;
  logic               scale_valid;
  logic               scale_ready;
  logic               shade_valid;
  logic               shade_ready;

  // Stage one: clamp inputs, split hue into sector and in-sector fraction.
  hsvrgb_sector u_sector (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_tvalid),
    .ready_o (in_tready),
    .value_i (in_tdata[0 +: hsvrgb_pkg::LEVEL_W]),
    .hue_i   (in_tdata[hsvrgb_pkg::LEVEL_W +: hsvrgb_pkg::LEVEL_W]),
    .sat_i   (in_tdata[2*hsvrgb_pkg::LEVEL_W +: hsvrgb_pkg::LEVEL_W]),
    .valid_o (sect_valid),
    .ready_i (sect_ready),
    .data_o  (sect_data)
  );

  // Stage two: saturation times fraction terms.
  hsvrgb_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (sect_valid),
    .ready_o (sect_ready),
    .data_i  (sect_data),
    .valid_o (scale_valid),
    .ready_i (scale_ready),
    .data_o  (scale_data)
  );

  // Stage three: p, q and t from value. Zero saturation makes all three equal
  // to value, so grey pixels need no separate path.
  hsvrgb_shade u_shade (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (scale_valid),
    .ready_o (scale_ready),
    .data_i  (scale_data),
    .valid_o (shade_valid),
    .ready_i (shade_ready),
    .data_o  (shade_data)
  );

  // Stage four: route by sector into the output register.
  hsvrgb_route u_route (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (shade_valid),
    .ready_o (shade_ready),
    .data_i  (shade_data),
    .valid_o (out_tvalid),
    .ready_i (out_tready),
    .data_o  (rgb_data)
  );

  assign out_tdata = hsvrgb_pkg::TDATA_W'(rgb_data);

endmodule
